// ===== rtl/gsbe_pkg.sv =====
// Shared types and constants for the stationary gyro bias estimator.
// No dependencies; every other file imports this package.
package gsbe_pkg;

  // default build-time sizes
  localparam int unsigned DEF_WINDOW_DEPTH = 64;
  localparam int unsigned DEF_SAMPLE_BITS  = 16;

  // configuration register widths
  localparam int unsigned THR_W      = 15;
  localparam int unsigned RUN_NEED_W = 8;
  localparam int unsigned RUN_W      = 9;
  localparam int unsigned CFG_DATA_W = 15;
  localparam int unsigned CFG_IDX_W  = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STILL_THRESHOLD  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUIET_RUN_NEEDED = 1'd1;

  // reset values of the configuration registers
  localparam logic [THR_W-1:0]      RST_STILL_THRESHOLD  = 15'd16;
  localparam logic [RUN_NEED_W-1:0] RST_QUIET_RUN_NEEDED = 8'd10;

  // per-beat control handed from the merge stage to the axis lanes
  typedef struct packed {
    logic upd;    // beat accepted this cycle
    logic still;  // sample judged still, goes into the window
    logic full;   // window full at the start of the beat
  } lane_ctrl_t;

endpackage

// ===== rtl/gsbe_lane.sv =====
// One axis lane: running window sum, bias extraction and sum update.
// Depends on gsbe_pkg (lane_ctrl_t).
module gsbe_lane
  import gsbe_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = DEF_WINDOW_DEPTH,
  parameter int unsigned SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
  input  logic                                                   clk,
  input  logic                                                   rst_n,
  input  lane_ctrl_t                                             ctrl,
  input  logic signed [SAMPLE_BITS-1:0]                          new_smp,
  input  logic signed [SAMPLE_BITS-1:0]                          old_smp,
  output logic signed [SAMPLE_BITS+$clog2(WINDOW_DEPTH)-1:0]     bias
);

  localparam int unsigned SUM_W = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
  localparam int unsigned SHIFT = $clog2(WINDOW_DEPTH + 1) - 1;
  localparam int unsigned EXT_W = SUM_W - SAMPLE_BITS;

  logic signed [SUM_W-1:0] sum_r;
  logic signed [SUM_W-1:0] sum_nxt;
  logic signed [SUM_W-1:0] new_ext;
  logic signed [SUM_W-1:0] old_ext;
  logic signed [SUM_W-1:0] sum_shr;

  // arithmetic shift is a floor divide by the depth; zero until window full
  assign sum_shr = sum_r >>> SHIFT;
  assign bias    = ctrl.full ? sum_shr : '0;

  // drop the oldest sample only once the window is full
  assign new_ext = {{EXT_W{new_smp[SAMPLE_BITS-1]}}, new_smp};
  assign old_ext = ctrl.full ? {{EXT_W{old_smp[SAMPLE_BITS-1]}}, old_smp} : '0;
  assign sum_nxt = sum_r + new_ext - old_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (ctrl.upd && ctrl.still) begin
      sum_r <= sum_nxt;
    end
  end

endmodule

// ===== rtl/gsbe_still.sv =====
// Merge stage: corrected z, quiet test and saturating quiet-run counter.
// Depends on gsbe_pkg (widths).
module gsbe_still
  import gsbe_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = DEF_WINDOW_DEPTH,
  parameter int unsigned SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
  input  logic                                                 clk,
  input  logic                                                 rst_n,
  input  logic                                                 upd,
  input  logic signed [SAMPLE_BITS-1:0]                        rate_z,
  input  logic signed [SAMPLE_BITS+$clog2(WINDOW_DEPTH)-1:0]   bias_z,
  input  logic [THR_W-1:0]                                     threshold,
  input  logic [RUN_NEED_W-1:0]                                run_needed,
  output logic signed [SAMPLE_BITS+$clog2(WINDOW_DEPTH):0]     corr_z,
  output logic                                                 still
);

  localparam int unsigned SUM_W = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
  localparam int unsigned CZ_W  = SUM_W + 1;
  localparam int unsigned CMP_W = (CZ_W > THR_W) ? CZ_W : THR_W;

  logic [RUN_W-1:0]  run_r;
  logic [RUN_W-1:0]  run_nxt;
  logic [RUN_W-1:0]  run_inc;
  logic [RUN_W-1:0]  need_ext;
  logic [CZ_W-1:0]   mag;
  logic [CMP_W-1:0]  mag_cmp;
  logic [CMP_W-1:0]  thr_cmp;
  logic              quiet;

  // corrected z at full width, magnitude and quiet test
  assign corr_z  = {{(CZ_W-SAMPLE_BITS){rate_z[SAMPLE_BITS-1]}}, rate_z}
                 - {bias_z[SUM_W-1], bias_z};
  assign mag     = corr_z[CZ_W-1] ? (~corr_z + 1'b1) : corr_z;
  assign mag_cmp = CMP_W'(mag);
  assign thr_cmp = CMP_W'(threshold);
  assign quiet   = mag_cmp < thr_cmp;

  // run counter: saturating count of quiet beats, clamped once still
  assign need_ext = RUN_W'(run_needed);
  assign run_inc  = !quiet ? '0 : ((&run_r) ? run_r : run_r + 1'b1);
  assign still    = run_inc > need_ext;
  assign run_nxt  = still ? need_ext + 1'b1 : run_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= '0;
    end else if (upd) begin
      run_r <= run_nxt;
    end
  end

endmodule

// ===== rtl/gyro_still_bias_estimator_top.sv =====
// Top level of the stationary gyro bias estimator: sample ring, fill and
// pointer tracking, config registers, output register. Depends on gsbe_pkg,
// gsbe_lane and gsbe_still.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   in      | in_valid, in_stall, in_rate_x/y/z       | sample in
//   out     | out_valid, out_stall, out_bias_*,       | result out
//           | out_bias_valid, out_is_still,           |
//           | out_corrected_z                         |
//   cfg     | cfg_we, cfg_index, cfg_wdata            | write only
//
// One beat per cycle while out_stall does not hold results back; each result is
// registered and appears in the cycle after its input beat. The limit is the sum
// update in each axis lane, which the next beat's bias depends on. Synchronous
// reset clears sums, counters and config; the sample ring is not cleared (slots
// are read only after being written). in_stall is high in the first cycle after
// reset and whenever the output register holds a beat that out_stall holds back.
module gyro_still_bias_estimator_top
  import gsbe_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = DEF_WINDOW_DEPTH,
  parameter int unsigned SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_rate_x,
  input  logic signed [SAMPLE_BITS-1:0] in_rate_y,
  input  logic signed [SAMPLE_BITS-1:0] in_rate_z,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_bias_x,
  output logic signed [SAMPLE_BITS-1:0] out_bias_y,
  output logic signed [SAMPLE_BITS-1:0] out_bias_z,
  output logic                          out_bias_valid,
  output logic                          out_is_still,
  output logic signed [SAMPLE_BITS:0]   out_corrected_z,
  // configuration
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata
);

  localparam int unsigned SUM_W  = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
  localparam int unsigned CZ_W   = SUM_W + 1;
  localparam int unsigned PTR_W  = $clog2(WINDOW_DEPTH);
  localparam int unsigned FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SMP3_W = 3 * SAMPLE_BITS;

  // config registers
  logic [THR_W-1:0]      thr_r;
  logic [RUN_NEED_W-1:0] need_r;

  // window tracking
  logic [PTR_W-1:0]      ptr_r;
  logic [PTR_W-1:0]      ptr_nxt;
  logic [FILL_W-1:0]     fill_r;
  logic [FILL_W-1:0]     fill_nxt;
  logic                  full;

  // sample ring and the registered oldest sample
  logic [SMP3_W-1:0]     ring_mem [WINDOW_DEPTH];
  logic [SMP3_W-1:0]     old_r;

  // handshake and output register
  logic                  live_r;
  logic                  acc;
  logic                  out_valid_r;
  logic signed [SAMPLE_BITS-1:0] bias_x_r;
  logic signed [SAMPLE_BITS-1:0] bias_y_r;
  logic signed [SAMPLE_BITS-1:0] bias_z_r;
  logic                  bias_valid_r;
  logic                  is_still_r;
  logic signed [SAMPLE_BITS:0]   corr_z_r;

  // lane and merge results
  lane_ctrl_t            ctrl;
  logic                  still;
  logic signed [SUM_W-1:0] bias_x;
  logic signed [SUM_W-1:0] bias_y;
  logic signed [SUM_W-1:0] bias_z;
  logic signed [CZ_W-1:0]  corr_z;

  // handshake: output register frees up when taken
  assign in_stall = !live_r || (out_valid_r && out_stall);
  assign acc      = in_valid && !in_stall;

  assign full       = fill_r >= FILL_W'(WINDOW_DEPTH);
  assign ctrl.upd   = acc;
  assign ctrl.still = still;
  assign ctrl.full  = full;

  // axis lanes
  gsbe_lane #(.WINDOW_DEPTH(WINDOW_DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_lane_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .new_smp (in_rate_x),
    .old_smp (old_r[3*SAMPLE_BITS-1:2*SAMPLE_BITS]),
    .bias    (bias_x)
  );

  gsbe_lane #(.WINDOW_DEPTH(WINDOW_DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_lane_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .new_smp (in_rate_y),
    .old_smp (old_r[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .bias    (bias_y)
  );

  gsbe_lane #(.WINDOW_DEPTH(WINDOW_DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_lane_z (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .new_smp (in_rate_z),
    .old_smp (old_r[SAMPLE_BITS-1:0]),
    .bias    (bias_z)
  );

  // merge: stillness decision on the corrected z rate
  gsbe_still #(.WINDOW_DEPTH(WINDOW_DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_still (
    .clk        (clk),
    .rst_n      (rst_n),
    .upd        (acc),
    .rate_z     (in_rate_z),
    .bias_z     (bias_z),
    .threshold  (thr_r),
    .run_needed (need_r),
    .corr_z     (corr_z),
    .still      (still)
  );

  // pointer and fill count advance on each still beat
  always_comb begin
    ptr_nxt  = ptr_r;
    fill_nxt = fill_r;
    if (acc && still) begin
      ptr_nxt  = (ptr_r == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : ptr_r + 1'b1;
      fill_nxt = full ? FILL_W'(WINDOW_DEPTH) : fill_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r  <= '0;
      fill_r <= '0;
    end else begin
      ptr_r  <= ptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  // ring: write the still sample, prefetch the slot the pointer moves to
  always_ff @(posedge clk) begin
    if (acc && still) begin
      ring_mem[ptr_r] <= {in_rate_x, in_rate_y, in_rate_z};
    end
    old_r <= ring_mem[ptr_nxt];
  end

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= RST_STILL_THRESHOLD;
      need_r <= RST_QUIET_RUN_NEEDED;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STILL_THRESHOLD:  thr_r  <= cfg_wdata[THR_W-1:0];
        REG_QUIET_RUN_NEEDED: need_r <= cfg_wdata[RUN_NEED_W-1:0];
        default: ;
      endcase
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      live_r <= 1'b1;
      if (acc) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (acc) begin
      bias_x_r     <= bias_x[SAMPLE_BITS-1:0];
      bias_y_r     <= bias_y[SAMPLE_BITS-1:0];
      bias_z_r     <= bias_z[SAMPLE_BITS-1:0];
      bias_valid_r <= full;
      is_still_r   <= still;
      corr_z_r     <= corr_z[SAMPLE_BITS:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_bias_x      = bias_x_r;
  assign out_bias_y      = bias_y_r;
  assign out_bias_z      = bias_z_r;
  assign out_bias_valid  = bias_valid_r;
  assign out_is_still    = is_still_r;
  assign out_corrected_z = corr_z_r;

  // fill count never runs past the window depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(WINDOW_DEPTH))
    else $error("fill count beyond window depth");

  // a still beat on a full window keeps it full
  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    acc && still && full |=> fill_r == FILL_W'(WINDOW_DEPTH))
    else $error("window lost its full state");

  // a result without a full window carries zero bias
  a_bias_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_bias_valid |->
      out_bias_x == '0 && out_bias_y == '0 && out_bias_z == '0)
    else $error("bias reported before window full");

  // pointer only moves on a still beat
  a_ptr_still: assert property (@(posedge clk) disable iff (!rst_n)
    !(acc && still) |=> ptr_r == $past(ptr_r))
    else $error("ring pointer moved without a still beat");

endmodule

// ===== bench/gsbe_result_checker.sv =====
// Result checker for the stationary gyro bias estimator: watches the sample,
// result and register ports, predicts every result beat and compares it.
// Depends on gsbe_pkg for widths, register indexes and reset values.
module gsbe_result_checker
  import gsbe_pkg::*;
(
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic signed [DEF_SAMPLE_BITS-1:0] in_rate_x,
  input  logic signed [DEF_SAMPLE_BITS-1:0] in_rate_y,
  input  logic signed [DEF_SAMPLE_BITS-1:0] in_rate_z,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [DEF_SAMPLE_BITS-1:0] out_bias_x,
  input  logic signed [DEF_SAMPLE_BITS-1:0] out_bias_y,
  input  logic signed [DEF_SAMPLE_BITS-1:0] out_bias_z,
  input  logic                              out_bias_valid,
  input  logic                              out_is_still,
  input  logic signed [DEF_SAMPLE_BITS:0]   out_corrected_z,
  input  logic                              cfg_we,
  input  logic [CFG_IDX_W-1:0]              cfg_index,
  input  logic [CFG_DATA_W-1:0]             cfg_wdata,
  output int                                fail_count,
  output int                                pending,
  output int                                beats_in,
  output int                                still_beats,
  output int                                full_beats
);

  localparam int unsigned SB    = DEF_SAMPLE_BITS;
  localparam int unsigned WIN   = DEF_WINDOW_DEPTH;
  localparam int unsigned SHIFT = $clog2(WIN);
  localparam int unsigned SUM_W = SB + SHIFT;

  typedef struct packed {
    logic signed [SB-1:0] bias_x;
    logic signed [SB-1:0] bias_y;
    logic signed [SB-1:0] bias_z;
    logic                 bias_valid;
    logic                 is_still;
    logic signed [SB:0]   corrected_z;
  } gyro_estimate_t;

  // mirrored window state and register copies
  logic signed [SB-1:0]    ring_mem [WIN][3];
  logic [SHIFT-1:0]        ring_ptr;
  logic [SHIFT:0]          fill_level;
  logic signed [SUM_W-1:0] axis_sum [3];
  logic [RUN_W-1:0]        quiet_run;
  logic [THR_W-1:0]        still_thr;
  logic [RUN_NEED_W-1:0]   run_needed;

  gyro_estimate_t pending_estimates [$];

  // one sample through the window: bias from the current sums, then the
  // stillness decision and the ring update
  function automatic gyro_estimate_t estimate_sample(input logic signed [SB-1:0] rx,
                                                     input logic signed [SB-1:0] ry,
                                                     input logic signed [SB-1:0] rz);
    gyro_estimate_t       est;
    logic signed [SB-1:0] rate [3];
    logic signed [SB-1:0] bias [3];
    logic [SB:0]          mag;
    int                   a;
    rate[0] = rx;
    rate[1] = ry;
    rate[2] = rz;
    est.bias_valid = (fill_level >= WIN);
    // arithmetic shift of the sum is the floor of the mean
    for (a = 0; a < 3; a++)
      bias[a] = est.bias_valid ? SB'(axis_sum[a] >>> SHIFT) : '0;
    est.corrected_z = rate[2] - bias[2];
    mag = est.corrected_z[SB] ? -est.corrected_z : est.corrected_z;

    // quiet run count, saturating
    if (mag < {2'b00, still_thr}) begin
      if (quiet_run != '1)
        quiet_run++;
    end else begin
      quiet_run = '0;
    end
    est.is_still = 1'b0;
    if (quiet_run > {1'b0, run_needed}) begin
      quiet_run    = {1'b0, run_needed} + 9'd1;
      est.is_still = 1'b1;
    end

    // still sample enters the ring, the oldest leaves once full
    if (est.is_still) begin
      if (fill_level >= WIN) begin
        for (a = 0; a < 3; a++)
          axis_sum[a] -= ring_mem[ring_ptr][a];
      end else begin
        fill_level++;
      end
      for (a = 0; a < 3; a++) begin
        ring_mem[ring_ptr][a] = rate[a];
        axis_sum[a] += rate[a];
      end
      ring_ptr++;
    end

    est.bias_x = bias[0];
    est.bias_y = bias[1];
    est.bias_z = bias[2];
    return est;
  endfunction

  task automatic compare_field(input string name, input logic signed [SB+1:0] want,
                               input logic signed [SB+1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // all three ports are sampled at the same edge the block sees
  always @(posedge clk) begin
    gyro_estimate_t head;
    if (!rst_n) begin
      ring_ptr    = '0;
      fill_level  = '0;
      axis_sum[0] = '0;
      axis_sum[1] = '0;
      axis_sum[2] = '0;
      quiet_run   = '0;
      still_thr   = RST_STILL_THRESHOLD;
      run_needed  = RST_QUIET_RUN_NEEDED;
      pending_estimates.delete();
      fail_count  = 0;
      pending     = 0;
      beats_in    = 0;
      still_beats = 0;
      full_beats  = 0;
    end else begin
      // result beat against the oldest prediction
      if (out_valid && !out_stall) begin
        if (pending_estimates.size() == 0) begin
          $display("%0t: result beat with no sample waiting for it", $time);
          fail_count++;
        end else begin
          head = pending_estimates.pop_front();
          compare_field("bias_x", head.bias_x, out_bias_x);
          compare_field("bias_y", head.bias_y, out_bias_y);
          compare_field("bias_z", head.bias_z, out_bias_z);
          compare_field("bias_valid", head.bias_valid, out_bias_valid);
          compare_field("is_still", head.is_still, out_is_still);
          compare_field("corrected_z", head.corrected_z, out_corrected_z);
        end
      end

      // register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_STILL_THRESHOLD:  still_thr  = cfg_wdata[THR_W-1:0];
          REG_QUIET_RUN_NEEDED: run_needed = cfg_wdata[RUN_NEED_W-1:0];
          default: ;
        endcase
      end

      // sample beat
      if (in_valid && !in_stall) begin
        head = estimate_sample(in_rate_x, in_rate_y, in_rate_z);
        pending_estimates.push_back(head);
        beats_in++;
        if (head.is_still)
          still_beats++;
        if (head.bias_valid)
          full_beats++;
      end
      pending = pending_estimates.size();
    end
  end

endmodule

// ===== bench/gyro_still_bias_estimator_top_test.sv =====
// Testbench top for the stationary gyro bias estimator: clock, reset, sample
// and register stimulus, and the verdict. Depends on gsbe_pkg, the block
// gyro_still_bias_estimator_top and gsbe_result_checker.
module gyro_still_bias_estimator_top_test;
  import gsbe_pkg::*;

  localparam int unsigned SB = DEF_SAMPLE_BITS;

  typedef enum logic {XY_RANDOM, XY_RAILS} xy_mode_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic signed [SB-1:0] in_rate_x = '0;
  logic signed [SB-1:0] in_rate_y = '0;
  logic signed [SB-1:0] in_rate_z = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [SB-1:0] out_bias_x;
  logic signed [SB-1:0] out_bias_y;
  logic signed [SB-1:0] out_bias_z;
  logic                 out_bias_valid;
  logic                 out_is_still;
  logic signed [SB:0]   out_corrected_z;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic no_idle = 1'b0;
  int   reg_writes = 0;
  int   fail_count;
  int   pending;
  int   beats_in;
  int   still_beats;
  int   full_beats;

  gyro_still_bias_estimator_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rate_x       (in_rate_x),
    .in_rate_y       (in_rate_y),
    .in_rate_z       (in_rate_z),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_bias_x      (out_bias_x),
    .out_bias_y      (out_bias_y),
    .out_bias_z      (out_bias_z),
    .out_bias_valid  (out_bias_valid),
    .out_is_still    (out_is_still),
    .out_corrected_z (out_corrected_z),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  gsbe_result_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rate_x       (in_rate_x),
    .in_rate_y       (in_rate_y),
    .in_rate_z       (in_rate_z),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_bias_x      (out_bias_x),
    .out_bias_y      (out_bias_y),
    .out_bias_z      (out_bias_z),
    .out_bias_valid  (out_bias_valid),
    .out_is_still    (out_is_still),
    .out_corrected_z (out_corrected_z),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending         (pending),
    .beats_in        (beats_in),
    .still_beats     (still_beats),
    .full_beats      (full_beats)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n)
      out_stall <= 1'b0;
    else
      out_stall <= !no_idle && ($urandom_range(0, 99) < 7);
  end

  // one sample beat, with a random gap first; valid stays up afterwards
  task automatic send_sample(input logic signed [SB-1:0] x, input logic signed [SB-1:0] y,
                             input logic signed [SB-1:0] z);
    while (!no_idle && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_rate_x <= x;
    in_rate_y <= y;
    in_rate_z <= z;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
  endtask

  // until every predicted result has come back
  task automatic wait_drained();
    do
      @(negedge clk);
    while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    reg_writes++;
  endtask

  // mostly quiet samples around a z centre, with bursts of full-range noise
  task automatic run_phase(input int count, input int centre, input int span,
                           input int noise_pct, input xy_mode_t mode);
    int burst;
    int zv;
    int n;
    burst = 0;
    for (n = 0; n < count; n++) begin
      if (burst == 0 && $urandom_range(0, 99) < noise_pct)
        burst = $urandom_range(1, 4);
      if (burst > 0) begin
        burst--;
        send_sample(SB'($urandom), SB'($urandom), SB'($urandom));
      end else begin
        zv = centre + int'($urandom_range(0, 2 * span)) - span;
        if (zv > 32767)
          zv = 32767;
        if (zv < -32768)
          zv = -32768;
        if (mode == XY_RAILS)
          send_sample(16'sh8000, 16'sh7FFF, zv[SB-1:0]);
        else
          send_sample(SB'($urandom), SB'($urandom), zv[SB-1:0]);
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    int i;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: rails of every field, then a quiet run at the reset settings,
    // the threshold boundary on both sides of zero
    send_sample(16'sh0000, 16'sh0000, 16'sh0000);
    send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000);
    send_sample(16'sh7FFF, 16'sh8000, 16'sd16);
    send_sample(16'sh8000, 16'sh7FFF, -16'sd16);
    for (i = 0; i < 12; i++)
      send_sample(i[0] ? 16'sh7FFF : 16'sh8000, i[0] ? 16'sh8000 : 16'sh7FFF,
                  (i % 3 == 0) ? 16'sd15 : (i % 3 == 1) ? -16'sd15 : 16'sd0);
    send_sample(16'sh1234, -16'sd4321, 16'sd16);
    send_sample(-16'sd1, 16'sd1, -16'sd15);
    in_valid <= 1'b0;
    wait_drained();

    // reset settings: fill the window near zero
    run_phase(300, 0, 7, 3, XY_RANDOM);
    wait_drained();

    // widest threshold, no run needed: window moves to a large negative z
    write_reg(REG_STILL_THRESHOLD, 15'd32767);
    write_reg(REG_QUIET_RUN_NEEDED, {7'($urandom), 8'd0});
    no_idle <= 1'b1;
    run_phase(250, -20000, 2000, 10, XY_RANDOM);
    no_idle <= 1'b0;
    wait_drained();

    // zero threshold: nothing is ever still
    write_reg(REG_STILL_THRESHOLD, 15'd0);
    write_reg(REG_QUIET_RUN_NEEDED, {7'($urandom), 8'd255});
    run_phase(100, -20000, 50, 20, XY_RANDOM);
    wait_drained();

    // longest run needed
    write_reg(REG_STILL_THRESHOLD, 15'd300);
    run_phase(350, -20000, 100, 0, XY_RANDOM);
    wait_drained();

    // rail x and y into every slot, z exactly constant
    write_reg(REG_STILL_THRESHOLD, 15'd32767);
    write_reg(REG_QUIET_RUN_NEEDED, {7'($urandom), 8'd0});
    run_phase(150, 10000, 0, 0, XY_RAILS);
    wait_drained();

    // threshold of one: only an exact bias match is quiet
    write_reg(REG_STILL_THRESHOLD, 15'd1);
    write_reg(REG_QUIET_RUN_NEEDED, {7'($urandom), 8'd3});
    run_phase(300, 10000, 0, 5, XY_RANDOM);

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Covered %0d sample beats, %0d judged still, %0d with a full window,",
             beats_in, still_beats, full_beats);
    $display("across %0d register writes including both threshold and run extremes",
             reg_writes);
    if (fail_count == 0)
      $display("gyro_still_bias_estimator_top verification clean");
    else
      $display("gyro_still_bias_estimator_top verification failed");
    $finish;
  end

  // hang guard
  initial begin
    #3000000;
    $display("Timed out with %0d results outstanding", pending);
    $display("gyro_still_bias_estimator_top verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/gsbe_pkg.sv
rtl/gsbe_lane.sv
rtl/gsbe_still.sv
rtl/gyro_still_bias_estimator_top.sv
bench/gsbe_result_checker.sv
bench/gyro_still_bias_estimator_top_test.sv
